// File: sv/isochronic_tone_generator_core_defines.svh
// Assertion macros for the isochronic tone generator core.
// Included by the RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ISOCHRONIC_TONE_GENERATOR_CORE_DEFINES_SVH
`define ISOCHRONIC_TONE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ITG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/itg_pkg.sv
// Shared constants, register codes and the quarter-wave sine table for the tone generator.
// No dependencies; the sine table is built at elaboration from a fixed-point Taylor series.
package itg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int COUNT_BITS      = 24;

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QSIZE = 1 << QBITS;

  // Sine values are Q30 in [0, 1.0], so 31 bits
  localparam int SINE_W = 31;
  localparam logic [SINE_W-1:0] SINE_ONE = SINE_W'(64'd1 << 30);

  localparam int AMP_W   = 16;
  localparam int ENV_W   = 17;  // Q16, up to and including 1.0
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE  = 3'd0,
    REG_PHASE_STEP = 3'd1,
    REG_CYCLE_LEN  = 3'd2,
    REG_ON_LEN     = 3'd3,
    REG_RAMP_LEN   = 3'd4
  } cfg_reg_e;

  localparam logic [AMP_W-1:0]      AMPLITUDE_RST  = 16'd32768;
  localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 32'd17895697;
  localparam logic [COUNT_BITS-1:0] CYCLE_LEN_RST  = 24'd12000;
  localparam logic [COUNT_BITS-1:0] ON_LEN_RST     = 24'd10200;
  localparam logic [COUNT_BITS-1:0] RAMP_LEN_RST   = 24'd2040;

  // sin(pi/2 * k / QSIZE) in Q30; elaboration use only
  function automatic logic [63:0] quarter_sine(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    x    = (k * HALF_PI_Q30 + ((64'd1 << QBITS) >> 1)) >> QBITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      prod = (term * x2) >> 30;
      case (n)
        1: term = prod / 64'd6;
        2: term = prod / 64'd20;
        3: term = prod / 64'd42;
        4: term = prod / 64'd72;
        5: term = prod / 64'd110;
        6: term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if ((n & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    return unsigned'(sum);
  endfunction

  typedef logic [SINE_W-1:0] sine_rom_t [QSIZE];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < QSIZE; i++) begin
      rom[i] = SINE_W'(quarter_sine(64'(i)));
    end
    return rom;
  endfunction

  // Entries 0 .. QSIZE-1; the quarter point itself is kept apart
  localparam sine_rom_t         SINE_ROM  = build_sine_rom();
  localparam logic [SINE_W-1:0] SINE_PEAK = SINE_W'(quarter_sine(64'(QSIZE)));

endpackage

// File: sv/isochronic_tone_generator_core.sv
// Isochronic tone generator: NCO sine times gain times trapezoid envelope, one sample per tick.
// Depends on itg_pkg and isochronic_tone_generator_core_defines.svh.
// Each accepted tick passes through the 16-step bit-serial envelope divider and two 8-digit
// shift-add multiplies; a new tick is taken only once the previous sample is in the output register.
// Reset (async, active low): phase and beat position cleared, registers at defaults, no output.
`include "isochronic_tone_generator_core_defines.svh"

module isochronic_tone_generator_core
  import itg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // input ticks
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [0] end_of_buffer, [7:1] zero
  // output samples
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic signed [SAMPLE_BITS-1:0] m_axis_tdata  // [15:0] sample
);

  // rounding position: Q62 product down to SAMPLE_BITS-1 fraction bits
  localparam int SHIFT = 62 - (SAMPLE_BITS - 1);
  localparam int MAG_W = 64 - SHIFT;
  localparam logic [MAG_W-1:0] LIM_NEG = MAG_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [MAG_W-1:0] LIM_POS = LIM_NEG - MAG_W'(1);

  localparam int DIV_STEPS = ENV_W - 1;   // quotient bits of the ramp division
  localparam int MUL_STEPS = 8;           // 4-bit digits of a 32-bit multiplier
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    ENV_ZERO = 2'd0,
    ENV_ONE  = 2'd1,
    ENV_DIV  = 2'd2
  } env_mode_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0]      amplitude_q;
  logic [PHASE_BITS-1:0] phase_step_q;
  logic [COUNT_BITS-1:0] cycle_len_q;
  logic [COUNT_BITS-1:0] on_len_q;
  logic [COUNT_BITS-1:0] ramp_len_q;

  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
  logic [COUNT_BITS-1:0] cycle_pos_q, cycle_pos_d;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic                  m_tvalid_q, m_tvalid_d;
  logic [SAMPLE_BITS-1:0] m_tdata_q, m_tdata_d;

  // per-item datapath (no reset)
  env_mode_e             mode_q, mode_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [DIV_STEPS-1:0]  quo_q, quo_d;
  logic [QBITS:0]        k_q, k_d;
  logic                  neg_q, neg_d;
  logic [SINE_W-1:0]     s_q, s_d;
  logic [31:0]           mcand_q, mcand_d;
  logic [63:0]           prod_q, prod_d;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_beat;
  logic out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = signed'(m_tdata_q);

  // ---------------------------------------------------------------------------
  // Accept-time decode: sine address and envelope segment from current state
  // ---------------------------------------------------------------------------
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QBITS:0]             k_raw;
  logic                       t_over_on;
  logic                       t_in_rise;
  logic                       t_in_fall;
  logic [COUNT_BITS:0]        t_plus_r;
  logic [COUNT_BITS-1:0]      pos_inc;

  assign idx   = phase_acc_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
  assign k_raw = {1'b0, idx[QBITS-1:0]};

  assign t_over_on = cycle_pos_q > on_len_q;
  assign t_in_rise = cycle_pos_q < ramp_len_q;
  assign t_plus_r  = {1'b0, cycle_pos_q} + {1'b0, ramp_len_q};
  assign t_in_fall = t_plus_r > {1'b0, on_len_q};
  assign pos_inc   = cycle_pos_q + COUNT_BITS'(1);

  // ---------------------------------------------------------------------------
  // Bit-serial divider step: one quotient bit per cycle, remainder stays < ramp
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS:0]    rem_x2;
  logic                   qbit;
  logic [DIV_STEPS-1:0]   quo_nx;
  logic [ENV_W-1:0]       env_val;

  assign rem_x2 = {rem_q, 1'b0};
  assign qbit   = rem_x2 >= {1'b0, ramp_len_q};
  assign quo_nx = {quo_q[DIV_STEPS-2:0], qbit};

  always_comb begin
    case (mode_q)
      ENV_ZERO: env_val = '0;
      ENV_DIV:  env_val = {1'b0, quo_nx};
      default:  env_val = ENV_W'(1) << DIV_STEPS;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shift-add multiplier step, 4-bit digit of prod_q low word per cycle
  // ---------------------------------------------------------------------------
  logic [35:0] mul_sum;
  logic [63:0] prod_nx;

  assign mul_sum = {4'b0, prod_q[63:32]} + mcand_q * prod_q[3:0];
  assign prod_nx = {mul_sum, prod_q[31:4]};

  // ---------------------------------------------------------------------------
  // Round, sign and saturate
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] sat;

  assign mag = prod_q[63:SHIFT] + MAG_W'(prod_q[SHIFT-1]);

  always_comb begin
    if (neg_q) begin
      sat = (mag > LIM_NEG) ? LIM_NEG : mag;
    end else begin
      sat = (mag > LIM_POS) ? LIM_POS : mag;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_acc_d = phase_acc_q;
    cycle_pos_d = cycle_pos_q;
    m_tvalid_d  = m_tvalid_q && !m_axis_tready;
    m_tdata_d   = m_tdata_q;
    mode_d      = mode_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    k_d         = k_q;
    neg_d       = neg_q;
    s_d         = s_q;
    mcand_d     = mcand_q;
    prod_d      = prod_q;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          // sine address: mirror odd quadrants, negate the second half turn
          k_d   = quad[0] ? ((QBITS+1)'(QSIZE) - k_raw) : k_raw;
          neg_d = quad[1];
          // envelope segment; strict compares, zero ramp means full level
          quo_d = '0;
          rem_d = cycle_pos_q;
          if (t_over_on) begin
            mode_d = ENV_ZERO;
          end else if (ramp_len_q == '0) begin
            mode_d = ENV_ONE;
          end else if (t_in_rise) begin
            mode_d = ENV_DIV;
          end else if (t_in_fall) begin
            mode_d = ENV_DIV;
            rem_d  = on_len_q - cycle_pos_q;
          end else begin
            mode_d = ENV_ONE;
          end
          // advance phase and beat position, or restart on end of buffer
          if (s_axis_tdata[0]) begin
            phase_acc_d = '0;
            cycle_pos_d = '0;
          end else begin
            phase_acc_d = phase_acc_q + phase_step_q;
            cycle_pos_d = (pos_inc >= cycle_len_q) ? '0 : pos_inc;
          end
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        s_d   = (k_q == (QBITS+1)'(QSIZE)) ? SINE_PEAK : SINE_ROM[k_q[QBITS-1:0]];
        quo_d = quo_nx;
        rem_d = qbit ? COUNT_BITS'(rem_x2 - {1'b0, ramp_len_q}) : rem_x2[COUNT_BITS-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          // gain times envelope first
          mcand_d = 32'(amplitude_q);
          prod_d  = {32'b0, 32'(env_val)};
          cnt_d   = '0;
          state_d = ST_MUL1;
        end
      end

      ST_MUL1: begin
        prod_d = prod_nx;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          // gain*envelope fits 32 bits; now times the sine magnitude
          mcand_d = prod_nx[31:0];
          prod_d  = {32'b0, 32'(s_q)};
          cnt_d   = '0;
          state_d = ST_MUL2;
        end
      end

      ST_MUL2: begin
        prod_d = prod_nx;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = neg_q ? SAMPLE_BITS'(-sat) : SAMPLE_BITS'(sat);
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      phase_acc_q <= '0;
      cycle_pos_q <= '0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_acc_q <= phase_acc_d;
      cycle_pos_q <= cycle_pos_d;
      m_tvalid_q  <= m_tvalid_d;
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q  <= AMPLITUDE_RST;
      phase_step_q <= PHASE_STEP_RST;
      cycle_len_q  <= CYCLE_LEN_RST;
      on_len_q     <= ON_LEN_RST;
      ramp_len_q   <= RAMP_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_AMPLITUDE:  amplitude_q  <= cfg_wdata_i[AMP_W-1:0];
        REG_PHASE_STEP: phase_step_q <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_CYCLE_LEN:  cycle_len_q  <= cfg_wdata_i[COUNT_BITS-1:0];
        REG_ON_LEN:     on_len_q     <= cfg_wdata_i[COUNT_BITS-1:0];
        REG_RAMP_LEN:   ramp_len_q   <= cfg_wdata_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    m_tdata_q <= m_tdata_d;
    mode_q    <= mode_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    k_q       <= k_d;
    neg_q     <= neg_d;
    s_q       <= s_d;
    mcand_q   <= mcand_d;
    prod_q    <= prod_d;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ITG_ASSERT_NEXT(a_beat_starts_div, in_beat, state_q == ST_DIV,
    "accepted tick did not start the envelope division")
  `ITG_ASSERT_NOW(a_rem_below_ramp, (state_q == ST_DIV) && (mode_q == ENV_DIV),
    rem_q < ramp_len_q, "divider remainder not below ramp length")
  `ITG_ASSERT_NEXT(a_pos_in_cycle, in_beat,
    (cycle_pos_q == '0) || (cycle_pos_q < $past(cycle_len_q)),
    "beat position left the cycle")
  `ITG_ASSERT_NOW(a_sine_bounded, state_q == ST_MUL2, s_q <= SINE_ONE,
    "sine magnitude above one")
  `ITG_ASSERT_NEXT(a_fin_waits, (state_q == ST_FIN) && m_tvalid_q && !m_axis_tready,
    (state_q == ST_FIN) && m_tvalid_q, "result dropped while output stalled")

endmodule

// File: dv/tb_isochronic_tone_generator_core.sv
// Self-checking testbench for isochronic_tone_generator_core: stream ticks in, checked samples out.
// Depends on itg_pkg for widths, register codes and reset values; the prediction is local.
`timescale 1ns / 100ps

module tb_isochronic_tone_generator_core;
  import itg_pkg::*;

  localparam int        DRAIN_CYCLES = 40;    // extra wait after the last sample is back
  localparam int        QUIET_LIMIT  = 2000;  // cycles without any beat or write
  localparam int        RANDOM_SETS  = 14;
  localparam int        TICKS_PER_SET = 64;
  localparam int        ROUND_SHIFT  = 62 - (SAMPLE_BITS - 1);
  localparam logic [63:0] QTR_TURN_Q30 = 64'd1686629713;  // pi/2 in Q30, rounded half up

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index_i = '0;
  logic [CFG_W-1:0]              cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // [0] end_of_buffer, [7:1] zero
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] m_axis_tdata;        // [15:0] sample

  isochronic_tone_generator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tone model: register copies and the two state counters
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0]      gain_reg  = AMPLITUDE_RST;
  logic [PHASE_BITS-1:0] step_reg  = PHASE_STEP_RST;
  logic [COUNT_BITS-1:0] cycle_reg = CYCLE_LEN_RST;
  logic [COUNT_BITS-1:0] on_reg    = ON_LEN_RST;
  logic [COUNT_BITS-1:0] ramp_reg  = RAMP_LEN_RST;
  logic [PHASE_BITS-1:0] nco_phase = '0;
  logic [COUNT_BITS-1:0] beat_pos  = '0;

  bit                            pending_ticks[$];     // end_of_buffer of ticks not yet sent
  logic signed [SAMPLE_BITS-1:0] expected_samples[$];

  bit idle_on = 1'b0;   // enables random gaps on the source and stalls on the sink
  int src_gap = 0;
  int sink_stall = 0;
  int error_count = 0;
  int ticks_sent = 0;
  int eob_sent = 0;
  int samples_checked = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  // sin(pi/2 * k / QSIZE) in Q30: Taylor series to x^15, truncated terms, clamped to [0, 1.0]
  function automatic logic [63:0] quarter_wave(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x    = (k * QTR_TURN_Q30 + (64'd1 << (QBITS - 1))) >> QBITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    return 64'(acc);
  endfunction

  // Trapezoid gain in Q16 at the current beat position
  function automatic logic [63:0] trapezoid_gain();
    logic [63:0] t;
    logic [63:0] on;
    logic [63:0] r;
    logic [63:0] g;
    t = 64'(beat_pos);
    on = 64'(on_reg);
    r = 64'(ramp_reg);
    if (t > on) begin
      g = 0;
    end else if (r == 0) begin
      g = 64'd65536;
    end else if (t < r) begin
      g = (t << 16) / r;             // rising ramp wins even when ramp exceeds on time
    end else if (t + r > on) begin
      g = ((on - t) << 16) / r;
    end else begin
      g = 64'd65536;
    end
    return g;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] tone_sample_now();
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [63:0]                k;
    logic [63:0]                mag;
    logic [63:0]                lim;
    logic [63:0]                res;
    idx  = nco_phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    k    = 64'(idx[QBITS-1:0]);
    if (quad[0]) begin
      k = 64'(QSIZE) - k;            // mirrored quadrant, may hit the peak point
    end
    mag = quarter_wave(k) * 64'(gain_reg) * trapezoid_gain();
    mag = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    lim = 64'd1 << (SAMPLE_BITS - 1);
    if (quad[1]) begin
      res = (mag > lim) ? -lim : -mag;
    end else begin
      res = (mag > lim - 1) ? lim - 1 : mag;
    end
    return SAMPLE_BITS'(res);
  endfunction

  function automatic void advance_tone(input bit eob);
    if (eob) begin
      nco_phase = '0;
      beat_pos  = '0;
    end else begin
      nco_phase = nco_phase + step_reg;
      beat_pos  = beat_pos + 1'b1;
      if (beat_pos >= cycle_reg) begin
        beat_pos = '0;               // also covers a zero length and a shortened cycle
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver: predicts on each accepted beat, refills from pending_ticks
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_samples.push_back(tone_sample_now());
        advance_tone(s_axis_tdata[0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          s_axis_tdata  <= {7'd0, pending_ticks[0]};
          s_axis_tvalid <= 1'b1;
          void'(pending_ticks.pop_front());
          if (idle_on && $urandom_range(0, 3) == 0) begin
            src_gap = $urandom_range(1, 5);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample monitor: checks each output beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        samples_checked++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, got %0d", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, m_axis_tdata);
            error_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) begin
          sink_stall = $urandom_range(1, 5);
        end
      end
    end
  end

  // Watchdog: no beat on either side and no register write for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Block idle: nothing left to send and every sample back, plus the pipeline depth
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (pending_ticks.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Only called while idle, so the model copy can change right away
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_AMPLITUDE:  gain_reg  = val[AMP_W-1:0];
      REG_PHASE_STEP: step_reg  = val[PHASE_BITS-1:0];
      REG_CYCLE_LEN:  cycle_reg = val[COUNT_BITS-1:0];
      REG_ON_LEN:     on_reg    = val[COUNT_BITS-1:0];
      REG_RAMP_LEN:   ramp_reg  = val[COUNT_BITS-1:0];
      default: ;                     // spare indexes are ignored by the block
    endcase
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] step,
                               input logic [CFG_W-1:0] cyc, input logic [CFG_W-1:0] on,
                               input logic [CFG_W-1:0] ramp);
    write_reg(REG_AMPLITUDE, gain);
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_CYCLE_LEN, cyc);
    write_reg(REG_ON_LEN, on);
    write_reg(REG_RAMP_LEN, ramp);
    settings_used++;
  endtask

  task automatic queue_tick(input bit eob);
    pending_ticks.push_back(eob);
    ticks_sent++;
    if (eob) begin
      eob_sent++;
    end
  endtask

  // Random register set: mostly short cycles so every envelope segment shows up
  task automatic pick_settings();
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] step;
    int unsigned      cyc;
    int unsigned      on;
    int unsigned      ramp;
    case ($urandom_range(0, 5))
      0:       gain = '0;
      1:       gain = 32'hFFFF;
      default: gain = $urandom_range(0, 16'hFFFF);
    endcase
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = 32'hFFFF_FFFF;
      2:       step = $urandom_range(0, 1 << 22);
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 11))
      0:       cyc = 0;
      1:       cyc = 24'hFF_FFFF;
      default: cyc = $urandom_range(1, 48);
    endcase
    case ($urandom_range(0, 11))
      0:       on = 24'hFF_FFFF;
      1:       on = 0;
      default: on = $urandom_range(0, (cyc > 48 ? 48 : cyc) + 4);
    endcase
    case ($urandom_range(0, 9))
      0:       ramp = 0;
      1:       ramp = 24'hFF_FFFF;
      default: ramp = $urandom_range(0, (on > 48 ? 48 : on) + 3);
    endcase
    load_settings(gain, step, cyc, on, ramp);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_RAMP_LEN + 1, (1 << CFG_IDX_W) - 1)), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int eob_per_64;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings, restart after an end-of-buffer mark
    queue_tick(1'b0);
    queue_tick(1'b1);
    queue_tick(1'b0);
    queue_tick(1'b1);
    settle();

    // Quarter-turn steps, full gain, flat envelope: zero, +peak saturates, zero, -peak
    load_settings(32'hFFFF, 32'h4000_0000, 32'd8, 32'd8, 32'd0);
    repeat (5) queue_tick(1'b0);
    settle();

    // Ramps shorter than the on time: rise, flat, fall, silent tail
    load_settings(32'd40000, 32'h0123_4567, 32'd6, 32'd4, 32'd2);
    repeat (6) queue_tick(1'b0);
    settle();

    // Ramp longer than the on time, maximal phase step; leaves the position at four
    load_settings(32'd51234, 32'hFFFF_FFFF, 32'd6, 32'd3, 32'd5);
    repeat (5) queue_tick(1'b0);
    settle();

    // Cycle shortened below the current position, spare indexes must not disturb anything
    write_reg(REG_CYCLE_LEN, 32'd2);
    for (int i = REG_RAMP_LEN + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 32'hFFFF_FFFF);
    end
    repeat (2) queue_tick(1'b0);
    settle();

    // Zero cycle length pins the position at zero
    write_reg(REG_CYCLE_LEN, 32'd0);
    repeat (3) queue_tick(1'b0);
    settle();

    // Random register sets; the last two run without gaps or stalls
    for (int p = 0; p < RANDOM_SETS; p++) begin
      pick_settings();
      idle_on = (p < RANDOM_SETS - 2) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       eob_per_64 = 0;
        1:       eob_per_64 = 8;
        default: eob_per_64 = 2;
      endcase
      for (int i = 0; i < TICKS_PER_SET; i++) begin
        queue_tick($urandom_range(0, 63) < eob_per_64);
      end
      settle();
    end

    if (expected_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
      error_count++;
    end
    $display("Drove %0d ticks (%0d end-of-buffer) under %0d register sets; checked %0d samples.",
             ticks_sent, eob_sent, settings_used + 1, samples_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
